/* sv/pism_pkg.sv */
package pism_pkg;

  // default widths
  localparam int SampleWidthDef    = 16;
  localparam int DegreeFracBitsDef = 15;

  // configuration port
  localparam int CfgIdxWidth = 3;

  localparam logic [CfgIdxWidth-1:0] RegBottomLeft  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegTopLeft     = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegTopRight    = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegBottomRight = 3'd3;

  // how the final degree is formed from the edge term
  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_ONE,
    KIND_TERM,
    KIND_ONE_MINUS
  } kind_e;

  // control that travels alongside the payload through the row
  typedef struct packed {
    logic  valid;
    kind_e kind;
  } ctl_t;

endpackage

/* sv/pism_ifs.sv */
// sample channel
interface pism_sample_if #(
  parameter int SAMPLE_WIDTH = pism_pkg::SampleWidthDef
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// degree channel
interface pism_degree_if #(
  parameter int DEGREE_FRAC_BITS = pism_pkg::DegreeFracBitsDef
);
  logic                      valid;
  logic                      ready;
  logic [DEGREE_FRAC_BITS:0] degree;

  modport source (output valid, output degree, input ready);
  modport sink (input valid, input degree, output ready);
endinterface

/* sv/pism_front_cell.sv */
module pism_front_cell #(
  parameter int SAMPLE_WIDTH     = pism_pkg::SampleWidthDef,
  parameter int DEGREE_FRAC_BITS = pism_pkg::DegreeFracBitsDef
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic signed [SAMPLE_WIDTH-1:0]              pt_a_i,
  input  logic signed [SAMPLE_WIDTH-1:0]              pt_b_i,
  input  logic signed [SAMPLE_WIDTH-1:0]              pt_c_i,
  input  logic signed [SAMPLE_WIDTH-1:0]              pt_d_i,
  input  logic                                        in_valid_i,
  input  logic signed [SAMPLE_WIDTH-1:0]              in_sample_i,
  output logic                                        in_ready_o,
  input  logic                                        out_ready_i,
  output pism_pkg::ctl_t                              out_ctl_o,
  output logic [SAMPLE_WIDTH+DEGREE_FRAC_BITS:0]      out_rem_o,
  output logic [SAMPLE_WIDTH-1:0]                     out_den_o
);

  localparam int W   = SAMPLE_WIDTH;
  localparam int F   = DEGREE_FRAC_BITS;
  localparam int Dvd = W + F + 1;

  logic signed [W+1:0] x2, x_e, a_e, b_e, c_e, d_e, ab_sum, cd_sum;
  logic signed [W:0]   xa_dif, bx_dif, xc_dif, dx_dif, ba_dif, dc_dif;
  logic [W-1:0]        num;
  logic [W-1:0]        den;
  pism_pkg::kind_e     kind;
  logic [Dvd-1:0]      rem_init;

  logic                valid_q;
  pism_pkg::kind_e     kind_q;
  logic [Dvd-1:0]      rem_q;
  logic [W-1:0]        den_q;

  // sign-extended operands and sums
  assign x_e    = (W+2)'(in_sample_i);
  assign a_e    = (W+2)'(pt_a_i);
  assign b_e    = (W+2)'(pt_b_i);
  assign c_e    = (W+2)'(pt_c_i);
  assign d_e    = (W+2)'(pt_d_i);
  assign x2     = x_e <<< 1;
  assign ab_sum = a_e + b_e;
  assign cd_sum = c_e + d_e;
  assign xa_dif = x_e[W:0] - a_e[W:0];
  assign bx_dif = b_e[W:0] - x_e[W:0];
  assign xc_dif = x_e[W:0] - c_e[W:0];
  assign dx_dif = d_e[W:0] - x_e[W:0];
  assign ba_dif = b_e[W:0] - a_e[W:0];
  assign dc_dif = d_e[W:0] - c_e[W:0];

  // segment select
  always_comb begin
    kind = pism_pkg::KIND_ZERO;
    num  = '0;
    den  = '0;
    if (x_e <= a_e) begin
      kind = pism_pkg::KIND_ZERO;
    end else if (x2 <= ab_sum) begin
      kind = pism_pkg::KIND_TERM;
      num  = xa_dif[W-1:0];
      den  = ba_dif[W-1:0];
    end else if (x_e < b_e) begin
      kind = pism_pkg::KIND_ONE_MINUS;
      num  = bx_dif[W-1:0];
      den  = ba_dif[W-1:0];
    end else if (x_e <= c_e) begin
      kind = pism_pkg::KIND_ONE;
    end else if (x2 <= cd_sum) begin
      kind = pism_pkg::KIND_ONE_MINUS;
      num  = xc_dif[W-1:0];
      den  = dc_dif[W-1:0];
    end else if (x_e < d_e) begin
      kind = pism_pkg::KIND_TERM;
      num  = dx_dif[W-1:0];
      den  = dc_dif[W-1:0];
    end
  end

  // dividend with half the divisor added for rounding
  assign rem_init = Dvd'({num, F'(0)}) + Dvd'(den >> 1);

  assign in_ready_o = !valid_q || out_ready_i;

  // control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      kind_q <= kind;
      rem_q  <= rem_init;
      den_q  <= den;
    end
  end

  assign out_ctl_o = '{valid: valid_q, kind: kind_q};
  assign out_rem_o = rem_q;
  assign out_den_o = den_q;

endmodule

/* sv/pism_div_cell.sv */
module pism_div_cell #(
  parameter int SAMPLE_WIDTH     = pism_pkg::SampleWidthDef,
  parameter int DEGREE_FRAC_BITS = pism_pkg::DegreeFracBitsDef,
  parameter int QUO_BIT          = 0
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  pism_pkg::ctl_t                         in_ctl_i,
  input  logic [SAMPLE_WIDTH+DEGREE_FRAC_BITS:0] in_rem_i,
  input  logic [SAMPLE_WIDTH-1:0]                in_den_i,
  input  logic [DEGREE_FRAC_BITS:0]              in_quo_i,
  output logic                                   in_ready_o,
  input  logic                                   out_ready_i,
  output pism_pkg::ctl_t                         out_ctl_o,
  output logic [SAMPLE_WIDTH+DEGREE_FRAC_BITS:0] out_rem_o,
  output logic [SAMPLE_WIDTH-1:0]                out_den_o,
  output logic [DEGREE_FRAC_BITS:0]              out_quo_o
);

  localparam int W   = SAMPLE_WIDTH;
  localparam int F   = DEGREE_FRAC_BITS;
  localparam int Dvd = W + F + 1;

  logic [Dvd:0]    trial;
  logic            fits;
  logic [Dvd-1:0]  rem_next;

  logic            valid_q;
  pism_pkg::kind_e kind_q;
  logic [Dvd-1:0]  rem_q;
  logic [W-1:0]    den_q;
  logic [F:0]      quo_q;

  // trial subtract of the shifted divisor
  assign trial    = {1'b0, in_rem_i} - ((Dvd+1)'(in_den_i) << QUO_BIT);
  assign fits     = !trial[Dvd];
  assign rem_next = fits ? trial[Dvd-1:0] : in_rem_i;

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_ctl_i.valid) begin
      kind_q <= in_ctl_i.kind;
      rem_q  <= rem_next;
      den_q  <= in_den_i;
      quo_q  <= {in_quo_i[F-1:0], fits};
    end
  end

  assign out_ctl_o = '{valid: valid_q, kind: kind_q};
  assign out_rem_o = rem_q;
  assign out_den_o = den_q;
  assign out_quo_o = quo_q;

endmodule

/* sv/pism_tail.sv */
module pism_tail #(
  parameter int DEGREE_FRAC_BITS = pism_pkg::DegreeFracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pism_pkg::ctl_t            in_ctl_i,
  input  logic [DEGREE_FRAC_BITS:0] in_quo_i,
  output logic                      in_ready_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [DEGREE_FRAC_BITS:0] out_degree_o
);

  localparam int F = DEGREE_FRAC_BITS;
  localparam logic [F+3:0] One = (F+4)'(1) << F;

  logic            sq_valid_q;
  pism_pkg::kind_e sq_kind_q;
  logic [2*F+1:0]  sq_q;
  logic            sq_ready;

  logic [2*F+2:0]  rounded;
  logic [F+3:0]    term;
  logic [F+3:0]    deg;

  logic            out_valid_q;
  logic [F:0]      degree_q;

  // square stage
  assign in_ready_o = !sq_valid_q || sq_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      sq_valid_q <= in_ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_ctl_i.valid) begin
      sq_kind_q <= in_ctl_i.kind;
      sq_q      <= (2*F+2)'(in_quo_i) * (2*F+2)'(in_quo_i);
    end
  end

  // twice the squared ratio, rounded half up, then the segment's degree
  assign rounded = (2*F+3)'(sq_q) + ((2*F+3)'(1) << (F-2));
  assign term    = rounded[2*F+2:F-1];

  always_comb begin
    case (sq_kind_q)
      pism_pkg::KIND_ZERO:      deg = '0;
      pism_pkg::KIND_ONE:       deg = One;
      pism_pkg::KIND_TERM:      deg = (term > One) ? One : term;
      pism_pkg::KIND_ONE_MINUS: deg = (term > One) ? One : One - term;
      default:                  deg = '0;
    endcase
  end

  // output register
  assign sq_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sq_ready) begin
      out_valid_q <= sq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_ready && sq_valid_q) begin
      degree_q <= deg[F:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_degree_o = degree_q;

endmodule

/* sv/pi_shape_membership.sv */
// channel   dir  payload                          transfer
// sample_i  in   sample, SAMPLE_WIDTH signed      valid & ready
// degree_o  out  degree, DEGREE_FRAC_BITS+1 bits  valid & ready
// cfg       in   cfg_idx_i, cfg_data_i            cfg_we_i
//
// one sample per cycle sustained while degree_o.ready holds; the stages are:
// a segment-select cell, one divider cell per quotient bit, a squarer and
// the output register
// every stage holds its item until the next one frees, so bubbles collapse
// and a stall on degree_o backs up stage by stage to sample_i.ready
// reset clears all valid flags and loads the breakpoints to 0, 1, 2 and 3 with W/2 fraction bits
module pi_shape_membership #(
  parameter int SAMPLE_WIDTH     = pism_pkg::SampleWidthDef,
  parameter int DEGREE_FRAC_BITS = pism_pkg::DegreeFracBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  pism_sample_if.sink                         sample_i,
  pism_degree_if.source                       degree_o,
  input  logic                                cfg_we_i,
  input  logic [pism_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [SAMPLE_WIDTH-1:0]             cfg_data_i
);

  localparam int W          = SAMPLE_WIDTH;
  localparam int F          = DEGREE_FRAC_BITS;
  localparam int Dvd        = W + F + 1;
  localparam int SampleFrac = W / 2;
  localparam int Stages     = F + 2;

  localparam logic [W-1:0] RstA = '0;
  localparam logic [W-1:0] RstB = W'(1) << SampleFrac;
  localparam logic [W-1:0] RstC = W'(2) << SampleFrac;
  localparam logic [W-1:0] RstD = W'(3) << SampleFrac;

  logic signed [W-1:0] bottom_left_q, top_left_q, top_right_q, bottom_right_q;

  pism_pkg::ctl_t ctl [Stages];
  logic [Dvd-1:0] rem [Stages];
  logic [W-1:0]   den [Stages];
  logic [F:0]     quo [Stages];
  logic           rdy [Stages];

  // breakpoint registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bottom_left_q  <= RstA;
      top_left_q     <= RstB;
      top_right_q    <= RstC;
      bottom_right_q <= RstD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pism_pkg::RegBottomLeft:  bottom_left_q  <= cfg_data_i;
        pism_pkg::RegTopLeft:     top_left_q     <= cfg_data_i;
        pism_pkg::RegTopRight:    top_right_q    <= cfg_data_i;
        pism_pkg::RegBottomRight: bottom_right_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // segment select and dividend setup
  pism_front_cell #(
    .SAMPLE_WIDTH     (W),
    .DEGREE_FRAC_BITS (F)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pt_a_i      (bottom_left_q),
    .pt_b_i      (top_left_q),
    .pt_c_i      (top_right_q),
    .pt_d_i      (bottom_right_q),
    .in_valid_i  (sample_i.valid),
    .in_sample_i (sample_i.sample),
    .in_ready_o  (sample_i.ready),
    .out_ready_i (rdy[0]),
    .out_ctl_o   (ctl[0]),
    .out_rem_o   (rem[0]),
    .out_den_o   (den[0])
  );

  assign quo[0] = '0;

  // divider row, most significant quotient bit first
  for (genvar i = 0; i <= F; i++) begin : g_div
    pism_div_cell #(
      .SAMPLE_WIDTH     (W),
      .DEGREE_FRAC_BITS (F),
      .QUO_BIT          (F - i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_ctl_i    (ctl[i]),
      .in_rem_i    (rem[i]),
      .in_den_i    (den[i]),
      .in_quo_i    (quo[i]),
      .in_ready_o  (rdy[i]),
      .out_ready_i (rdy[i+1]),
      .out_ctl_o   (ctl[i+1]),
      .out_rem_o   (rem[i+1]),
      .out_den_o   (den[i+1]),
      .out_quo_o   (quo[i+1])
    );
  end

  // squarer and output register
  pism_tail #(
    .DEGREE_FRAC_BITS (F)
  ) u_tail (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ctl_i     (ctl[Stages-1]),
    .in_quo_i     (quo[Stages-1]),
    .in_ready_o   (rdy[Stages-1]),
    .out_ready_i  (degree_o.ready),
    .out_valid_o  (degree_o.valid),
    .out_degree_o (degree_o.degree)
  );

  // degree never exceeds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    degree_o.valid |-> degree_o.degree <= ((F+1)'(1) << F))
    else $error("degree above one");

  // an accepted sample lands in the segment-select cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_i.valid && sample_i.ready |=> ctl[0].valid)
    else $error("accepted sample lost at the front cell");

  // a breakpoint write takes effect on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == pism_pkg::RegTopLeft |=> top_left_q == $past(cfg_data_i))
    else $error("top_left write not taken");

endmodule
